// ===== design/sobb_pkg.sv =====
`default_nettype none
package sobb_pkg;

  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned DivSteps  = 15;
  localparam logic [14:0] NormMax   = 15'd16384;

  typedef struct packed {
    logic             hit;
    logic             zero;
    logic [30:0]      radius;
    logic [2:0][31:0] pt;
    logic [2:0][31:0] mag;
    logic [2:0]       neg;
  } carry_t;

  typedef struct packed {
    carry_t      ctl;
    logic [63:0] dist2;
  } geo_t;

  typedef struct packed {
    carry_t      ctl;
    logic [31:0] distance;
  } root_t;

  typedef struct packed {
    logic             hit;
    logic             degenerate;
    logic [2:0][31:0] point;
    logic [2:0][15:0] normal;
    logic [30:0]      penetration;
  } res_t;

endpackage
`default_nettype wire

// ===== design/sobb_pair_if.sv =====
`default_nettype none
interface sobb_pair_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sphere_x;
  logic signed [31:0] sphere_y;
  logic signed [31:0] sphere_z;
  logic [30:0]        sphere_radius;
  logic signed [31:0] box_x;
  logic signed [31:0] box_y;
  logic signed [31:0] box_z;
  logic [30:0]        half_x;
  logic [30:0]        half_y;
  logic [30:0]        half_z;
  logic signed [15:0] quat_w;
  logic [44:0]        quat_xyz;

  modport source(output valid, sphere_x, sphere_y, sphere_z, sphere_radius, box_x, box_y,
                 box_z, half_x, half_y, half_z, quat_w, quat_xyz, input ready);
  modport sink(input valid, sphere_x, sphere_y, sphere_z, sphere_radius, box_x, box_y,
               box_z, half_x, half_y, half_z, quat_w, quat_xyz, output ready);
endinterface
`default_nettype wire

// ===== design/sobb_result_if.sv =====
`default_nettype none
interface sobb_result_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic               degenerate;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic [30:0]        penetration;

  modport source(output valid, hit, degenerate, point_x, point_y, point_z, normal_x,
                 normal_y, normal_z, penetration, input ready);
  modport sink(input valid, hit, degenerate, point_x, point_y, point_z, normal_x,
               normal_y, normal_z, penetration, output ready);
endinterface
`default_nettype wire

// ===== design/sobb_geom.sv =====
`default_nettype none
module sobb_geom import sobb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  sobb_pair_if.sink   pair,
  output logic        vld,
  output geo_t        geo
);

  localparam logic signed [33:0] One = 34'sd268435456;

  function automatic logic signed [17:0] rnd14(input logic signed [33:0] v);
    logic signed [33:0] a;
    a = v + 34'sd8192;
    return a[31:14];
  endfunction

  logic v [9];

  logic signed [31:0] s_in [3];
  logic signed [31:0] c_in [3];
  logic [30:0]        h_in [3];
  logic signed [31:0] qw, qx, qy, qz;

  logic signed [32:0] d1 [3];
  logic signed [31:0] c1 [3], s1 [3];
  logic [30:0]        h1 [3];
  logic [30:0]        r1;
  logic signed [31:0] xx1, yy1, zz1, xy1, xz1, yz1, wx1, wy1, wz1;

  logic signed [32:0] d2 [3];
  logic signed [31:0] c2 [3], s2 [3];
  logic [30:0]        h2 [3];
  logic [30:0]        r2;
  logic signed [17:0] ax2 [3][3];

  logic signed [50:0] m3 [3][3];
  logic signed [17:0] ax3 [3][3];
  logic signed [31:0] c3 [3], s3 [3];
  logic [30:0]        h3 [3];
  logic [30:0]        r3;

  logic signed [31:0] p4 [3];
  logic signed [17:0] ax4 [3][3];
  logic signed [31:0] c4 [3], s4 [3];
  logic [30:0]        r4;

  logic signed [49:0] n5 [3][3];
  logic signed [31:0] c5 [3], s5 [3];
  logic [30:0]        r5;

  logic signed [31:0] pt6 [3], s6 [3];
  logic [30:0]        r6;

  logic [31:0]        pt7 [3], mag7 [3];
  logic [2:0]         neg7;
  logic [30:0]        r7;

  logic [63:0]        sq8 [3];
  logic [63:0]        rr8;
  logic [31:0]        pt8 [3], mag8 [3];
  logic [2:0]         neg8;
  logic [30:0]        r8;

  logic signed [31:0] p_next [3];
  logic signed [31:0] pt_next [3];
  logic [31:0]        mag_next [3];
  logic [2:0]         neg_next;
  logic [63:0]        dist2_next;

  assign pair.ready = en;
  assign s_in[0] = pair.sphere_x;
  assign s_in[1] = pair.sphere_y;
  assign s_in[2] = pair.sphere_z;
  assign c_in[0] = pair.box_x;
  assign c_in[1] = pair.box_y;
  assign c_in[2] = pair.box_z;
  assign h_in[0] = pair.half_x;
  assign h_in[1] = pair.half_y;
  assign h_in[2] = pair.half_z;
  assign qw = 32'(pair.quat_w);
  assign qx = 32'(signed'(pair.quat_xyz[14:0]));
  assign qy = 32'(signed'(pair.quat_xyz[29:15]));
  assign qz = 32'(signed'(pair.quat_xyz[44:30]));

  always_comb begin
    logic signed [52:0] dot;
    logic signed [38:0] rn;
    logic signed [38:0] hs;
    for (int i = 0; i < 3; i++) begin
      dot = 53'(m3[i][0]) + 53'(m3[i][1]) + 53'(m3[i][2]) + 53'sd8192;
      rn  = dot[52:14];
      hs  = signed'({8'd0, h3[i]});
      if (rn > hs) begin
        p_next[i] = hs[31:0];
      end else if (rn < -hs) begin
        p_next[i] = 32'(-hs);
      end else begin
        p_next[i] = rn[31:0];
      end
    end
  end

  always_comb begin
    logic signed [51:0] acc;
    logic signed [37:0] rn;
    logic signed [38:0] t;
    for (int k = 0; k < 3; k++) begin
      acc = 52'(n5[k][0]) + 52'(n5[k][1]) + 52'(n5[k][2]) + 52'sd8192;
      rn  = acc[51:14];
      t   = 39'(rn) + 39'(c5[k]);
      if (t > 39'sd2147483647) begin
        pt_next[k] = 32'sh7fffffff;
      end else if (t < -39'sd2147483648) begin
        pt_next[k] = 32'sh80000000;
      end else begin
        pt_next[k] = t[31:0];
      end
    end
  end

  always_comb begin
    logic signed [32:0] df;
    for (int k = 0; k < 3; k++) begin
      df = 33'(pt6[k]) - 33'(s6[k]);
      neg_next[k] = df[32];
      mag_next[k] = df[32] ? 32'(-df) : df[31:0];
    end
  end

  always_comb begin
    logic [65:0] sum;
    sum = 66'(sq8[0]) + 66'(sq8[1]) + 66'(sq8[2]);
    dist2_next = (sum[65:64] != 2'b00) ? '1 : sum[63:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < 9; j++) v[j] <= 1'b0;
    end else if (en) begin
      v[0] <= pair.valid;
      for (int j = 1; j < 9; j++) v[j] <= v[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        d1[k] <= 33'(s_in[k]) - 33'(c_in[k]);
        c1[k] <= c_in[k];
        s1[k] <= s_in[k];
        h1[k] <= h_in[k];
      end
      r1  <= pair.sphere_radius;
      xx1 <= qx * qx;
      yy1 <= qy * qy;
      zz1 <= qz * qz;
      xy1 <= qx * qy;
      xz1 <= qx * qz;
      yz1 <= qy * qz;
      wx1 <= qw * qx;
      wy1 <= qw * qy;
      wz1 <= qw * qz;

      ax2[0][0] <= rnd14(One - ((34'(yy1) + 34'(zz1)) <<< 1));
      ax2[0][1] <= rnd14((34'(xy1) + 34'(wz1)) <<< 1);
      ax2[0][2] <= rnd14((34'(xz1) - 34'(wy1)) <<< 1);
      ax2[1][0] <= rnd14((34'(xy1) - 34'(wz1)) <<< 1);
      ax2[1][1] <= rnd14(One - ((34'(xx1) + 34'(zz1)) <<< 1));
      ax2[1][2] <= rnd14((34'(yz1) + 34'(wx1)) <<< 1);
      ax2[2][0] <= rnd14((34'(xz1) + 34'(wy1)) <<< 1);
      ax2[2][1] <= rnd14((34'(yz1) - 34'(wx1)) <<< 1);
      ax2[2][2] <= rnd14(One - ((34'(xx1) + 34'(yy1)) <<< 1));
      d2 <= d1;
      c2 <= c1;
      s2 <= s1;
      h2 <= h1;
      r2 <= r1;

      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          m3[i][k] <= 51'(d2[k]) * 51'(ax2[i][k]);
        end
      end
      ax3 <= ax2;
      c3  <= c2;
      s3  <= s2;
      h3  <= h2;
      r3  <= r2;

      p4  <= p_next;
      ax4 <= ax3;
      c4  <= c3;
      s4  <= s3;
      r4  <= r3;

      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          n5[k][i] <= 50'(p4[i]) * 50'(ax4[i][k]);
        end
      end
      c5 <= c4;
      s5 <= s4;
      r5 <= r4;

      pt6 <= pt_next;
      s6  <= s5;
      r6  <= r5;

      for (int k = 0; k < 3; k++) begin
        pt7[k]  <= pt6[k];
        mag7[k] <= mag_next[k];
      end
      neg7 <= neg_next;
      r7   <= r6;

      for (int k = 0; k < 3; k++) begin
        sq8[k] <= 64'(mag7[k]) * 64'(mag7[k]);
      end
      rr8  <= 64'(r7) * 64'(r7);
      pt8  <= pt7;
      mag8 <= mag7;
      neg8 <= neg7;
      r8   <= r7;

      geo.dist2      <= dist2_next;
      geo.ctl.hit    <= dist2_next <= rr8;
      geo.ctl.zero   <= dist2_next == 64'd0;
      geo.ctl.radius <= r8;
      for (int k = 0; k < 3; k++) begin
        geo.ctl.pt[k]  <= pt8[k];
        geo.ctl.mag[k] <= mag8[k];
      end
      geo.ctl.neg <= neg8;
    end
  end

  assign vld = v[8];

endmodule
`default_nettype wire

// ===== design/sobb_sqrt.sv =====
`default_nettype none
module sobb_sqrt import sobb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  vld_in,
  input  geo_t  geo,
  output logic  vld,
  output root_t rt
);

  logic        v    [SqrtSteps+1];
  logic [33:0] rem  [SqrtSteps+1];
  logic [31:0] root [SqrtSteps+1];
  logic [63:0] rad  [SqrtSteps+1];
  carry_t      car  [SqrtSteps+1];

  assign v[0]    = vld_in;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign rad[0]  = geo.dist2;
  assign car[0]  = geo.ctl;

  for (genvar j = 0; j < SqrtSteps; j++) begin : g_step
    logic [35:0] rs;
    logic [35:0] tr;
    assign rs = {rem[j], rad[j][63:62]};
    assign tr = {2'b00, root[j], 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j+1] <= 1'b0;
      end else if (en) begin
        v[j+1] <= v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (rs >= tr) begin
          rem[j+1]  <= 34'(rs - tr);
          root[j+1] <= {root[j][30:0], 1'b1};
        end else begin
          rem[j+1]  <= rs[33:0];
          root[j+1] <= {root[j][30:0], 1'b0};
        end
        rad[j+1] <= {rad[j][61:0], 2'b00};
        car[j+1] <= car[j];
      end
    end
  end

  assign vld         = v[SqrtSteps];
  assign rt.ctl      = car[SqrtSteps];
  assign rt.distance = root[SqrtSteps];

endmodule
`default_nettype wire

// ===== design/sobb_norm.sv =====
`default_nettype none
module sobb_norm import sobb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  vld_in,
  input  root_t rt,
  output logic  vld,
  output res_t  res
);

  logic        v   [DivSteps+1];
  logic [46:0] rm  [DivSteps+1][3];
  logic [14:0] qt  [DivSteps+1][3];
  logic [31:0] dv  [DivSteps+1];
  carry_t      car [DivSteps+1];
  logic        vo;

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        rm[0][k] <= {1'b0, rt.ctl.mag[k], 14'd0} + 47'(rt.distance[31:1]);
        qt[0][k] <= '0;
      end
      dv[0]  <= rt.distance;
      car[0] <= rt.ctl;
    end
  end

  for (genvar j = 0; j < DivSteps; j++) begin : g_step
    logic [46:0] sub;
    assign sub = 47'(dv[j]) << (DivSteps - 1 - j);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j+1] <= 1'b0;
      end else if (en) begin
        v[j+1] <= v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int k = 0; k < 3; k++) begin
          if (rm[j][k] >= sub) begin
            rm[j+1][k] <= rm[j][k] - sub;
            qt[j+1][k] <= {qt[j][k][13:0], 1'b1};
          end else begin
            rm[j+1][k] <= rm[j][k];
            qt[j+1][k] <= {qt[j][k][13:0], 1'b0};
          end
        end
        dv[j+1]  <= dv[j];
        car[j+1] <= car[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (en) begin
      vo <= v[DivSteps];
    end
  end

  always_ff @(posedge clk) begin
    logic        h;
    logic        z;
    logic [14:0] qc;
    if (en) begin
      h = car[DivSteps].hit;
      z = car[DivSteps].zero;
      res.hit        <= h;
      res.degenerate <= h && z;
      res.point      <= car[DivSteps].pt;
      for (int k = 0; k < 3; k++) begin
        qc = (qt[DivSteps][k] > NormMax) ? NormMax : qt[DivSteps][k];
        if (h && !z) begin
          res.normal[k] <= car[DivSteps].neg[k] ? -16'(qc) : 16'(qc);
        end else begin
          res.normal[k] <= '0;
        end
      end
      res.penetration <= h ? car[DivSteps].radius - dv[DivSteps][30:0] : 31'd0;
    end
  end

  assign vld = vo;

endmodule
`default_nettype wire

// ===== design/sphere_obb_contact_test_unit.sv =====
// Sphere against oriented box contact test.
// A pair passes through nine arithmetic stages, a 32-stage square root and a
// 15-stage divider between an input and an output register to its result beat.
// Throughput is one pair per cycle; a stalled output holds every stage in place.
// Synchronous reset clears all valid bits; the data registers are not reset.
`default_nettype none
module sphere_obb_contact_test_unit import sobb_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  sobb_pair_if.sink      pair,
  sobb_result_if.source  result
);

  logic  en;
  logic  geo_vld;
  geo_t  geo;
  logic  rt_vld;
  root_t rt;
  logic  res_vld;
  res_t  res;

  assign en = !res_vld || result.ready;

  sobb_geom u_geom (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .pair (pair),
    .vld  (geo_vld),
    .geo  (geo)
  );

  sobb_sqrt u_sqrt (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .vld_in (geo_vld),
    .geo    (geo),
    .vld    (rt_vld),
    .rt     (rt)
  );

  sobb_norm u_norm (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .vld_in (rt_vld),
    .rt     (rt),
    .vld    (res_vld),
    .res    (res)
  );

  assign result.valid       = res_vld;
  assign result.hit         = res.hit;
  assign result.degenerate  = res.degenerate;
  assign result.point_x     = res.point[0];
  assign result.point_y     = res.point[1];
  assign result.point_z     = res.point[2];
  assign result.normal_x    = res.normal[0];
  assign result.normal_y    = res.normal[1];
  assign result.normal_z    = res.normal[2];
  assign result.penetration = res.penetration;

endmodule
`default_nettype wire

// ===== dv/sobb_tb_if.sv =====
`timescale 1ns / 100ps
`default_nettype none
// The block's channel interfaces come from the design folder. This file holds the
// typed pair beat layout that the checker and the stimulus share.
package sobb_tb_pkg;

  typedef struct packed {
    logic signed [31:0] sx, sy, sz;
    logic [30:0]        radius;
    logic signed [31:0] bx, by, bz;
    logic [30:0]        hx, hy, hz;
    logic signed [15:0] qw;
    logic [44:0]        qxyz;
  } pair_beat_t;

endpackage
`default_nettype wire

// ===== dv/sobb_checker.sv =====
`timescale 1ns / 100ps
`default_nettype none
module sobb_checker import sobb_pkg::*; import sobb_tb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  sobb_pair_if  pair,
  sobb_result_if result,
  output int    fail_count,
  output int    pending,
  output int    hit_count,
  output int    degen_count
);

  res_t contact_q[$];

  function automatic longint round_shift(longint v, int n);
    longint a;
    a = v + (longint'(1) << (n - 1));
    return a >>> n;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic res_t predict_contact(pair_beat_t p);
    res_t       o;
    longint     s[3], c[3], h[3], d[3], ax[3][3], pr[3], pt[3], df[3];
    longint     w, x, y, z, one, dot, acc;
    logic [63:0] r, dist2, sq, ad, distance, q;
    o = '0;
    one = longint'(1) << 28;
    s[0] = p.sx; s[1] = p.sy; s[2] = p.sz;
    c[0] = p.bx; c[1] = p.by; c[2] = p.bz;
    h[0] = p.hx; h[1] = p.hy; h[2] = p.hz;
    for (int k = 0; k < 3; k++) d[k] = s[k] - c[k];
    r = p.radius;
    w = p.qw;
    x = signed'(p.qxyz[14:0]);
    y = signed'(p.qxyz[29:15]);
    z = signed'(p.qxyz[44:30]);
    ax[0][0] = round_shift(one - 2 * (y * y + z * z), 14);
    ax[0][1] = round_shift(2 * (x * y + w * z), 14);
    ax[0][2] = round_shift(2 * (x * z - w * y), 14);
    ax[1][0] = round_shift(2 * (x * y - w * z), 14);
    ax[1][1] = round_shift(one - 2 * (x * x + z * z), 14);
    ax[1][2] = round_shift(2 * (y * z + w * x), 14);
    ax[2][0] = round_shift(2 * (x * z + w * y), 14);
    ax[2][1] = round_shift(2 * (y * z - w * x), 14);
    ax[2][2] = round_shift(one - 2 * (x * x + y * y), 14);
    for (int i = 0; i < 3; i++) begin
      dot = d[0] * ax[i][0] + d[1] * ax[i][1] + d[2] * ax[i][2];
      pr[i] = clamp(round_shift(dot, 14), -h[i], h[i]);
    end
    dist2 = 0;
    for (int k = 0; k < 3; k++) begin
      acc = pr[0] * ax[0][k] + pr[1] * ax[1][k] + pr[2] * ax[2][k];
      pt[k] = clamp(c[k] + round_shift(acc, 14), -64'sd2147483648, 64'sd2147483647);
      df[k] = pt[k] - s[k];
      ad = df[k] < 0 ? -df[k] : df[k];
      sq = ad * ad;
      dist2 = (dist2 > ~64'd0 - sq) ? ~64'd0 : dist2 + sq;
      o.point[k] = pt[k][31:0];
    end
    o.hit = dist2 <= r * r;
    if (o.hit) begin
      distance = floor_sqrt(dist2);
      o.penetration = 31'(r - distance);
      if (dist2 == 0) begin
        o.degenerate = 1'b1;
      end else begin
        for (int k = 0; k < 3; k++) begin
          ad = df[k] < 0 ? -df[k] : df[k];
          q = ((ad << 14) + distance / 2) / distance;
          if (q > 16384) q = 16384;
          o.normal[k] = df[k] < 0 ? -16'(q) : 16'(q);
        end
      end
    end
    return o;
  endfunction

  task automatic compare_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  assign pending = contact_q.size();

  initial begin
    fail_count = 0;
    hit_count = 0;
    degen_count = 0;
  end

  always @(posedge clk) begin
    pair_beat_t pb;
    res_t       e;
    if (!rst) begin
      if (pair.valid && pair.ready) begin
        pb = '{pair.sphere_x, pair.sphere_y, pair.sphere_z, pair.sphere_radius,
               pair.box_x, pair.box_y, pair.box_z, pair.half_x, pair.half_y,
               pair.half_z, pair.quat_w, pair.quat_xyz};
        contact_q = {contact_q, predict_contact(pb)};
      end
      if (result.valid && result.ready) begin
        if (contact_q.size() == 0) begin
          $error("result beat with no pair outstanding");
          fail_count++;
        end else begin
          e = contact_q.pop_front();
          hit_count += e.hit;
          degen_count += e.degenerate;
          compare_field("hit", e.hit, result.hit);
          compare_field("degenerate", e.degenerate, result.degenerate);
          compare_field("point_x", signed'(e.point[0]), result.point_x);
          compare_field("point_y", signed'(e.point[1]), result.point_y);
          compare_field("point_z", signed'(e.point[2]), result.point_z);
          compare_field("normal_x", signed'(e.normal[0]), result.normal_x);
          compare_field("normal_y", signed'(e.normal[1]), result.normal_y);
          compare_field("normal_z", signed'(e.normal[2]), result.normal_z);
          compare_field("penetration", e.penetration, result.penetration);
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import sobb_tb_pkg::*;

  localparam int Latency = 58;
  localparam int RandomPairs = 430;
  localparam longint CycleLimit = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count, pending, hit_count, degen_count;
  int   sent;
  longint cycles = 0;

  sobb_pair_if   pair ();
  sobb_result_if result ();

  sphere_obb_contact_test_unit u_dut (.clk(clk), .rst(rst), .pair(pair), .result(result));

  sobb_checker u_chk (.clk(clk), .rst(rst), .pair(pair), .result(result),
    .fail_count(fail_count), .pending(pending), .hit_count(hit_count),
    .degen_count(degen_count));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic int gap_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // The result side stalls on its own; some windows run with ready held high.
  initial begin
    int n;
    result.ready = 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 9) == 0) begin
        result.ready <= 1'b1;
        repeat ($urandom_range(50, 200)) @(posedge clk);
      end
      n = gap_len();
      if (n > 0) begin
        result.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      result.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom;
      default: return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
    endcase
  endfunction

  function automatic logic [30:0] rand_size();
    case ($urandom_range(0, 7))
      0: return 31'h7fff_ffff;
      1: return 31'($urandom);
      2: return 31'd0;
      default: return 31'($urandom_range(0, 32'h0010_0000));
    endcase
  endfunction

  function automatic logic [14:0] rand_q15();
    return $urandom_range(0, 3) == 0 ? 15'($urandom) : 15'($urandom_range(0, 16384) - 8192);
  endfunction

  function automatic pair_beat_t rand_pair();
    pair_beat_t p;
    p.bx = rand_word(); p.by = rand_word(); p.bz = rand_word();
    if ($urandom_range(0, 3) != 0) begin
      p.sx = p.bx + 32'($signed($urandom_range(0, 32'h0030_0000)) - 32'sh0018_0000);
      p.sy = p.by + 32'($signed($urandom_range(0, 32'h0030_0000)) - 32'sh0018_0000);
      p.sz = p.bz + 32'($signed($urandom_range(0, 32'h0030_0000)) - 32'sh0018_0000);
    end else begin
      p.sx = rand_word(); p.sy = rand_word(); p.sz = rand_word();
    end
    p.radius = rand_size();
    p.hx = rand_size(); p.hy = rand_size(); p.hz = rand_size();
    case ($urandom_range(0, 4))
      0: begin p.qw = 16'sd16384; p.qxyz = '0; end
      1: begin p.qw = 16'($urandom); p.qxyz = 45'({$urandom, $urandom}); end
      default: begin
        p.qw = 16'($signed($urandom_range(0, 32768)) - 16384);
        p.qxyz = {rand_q15(), rand_q15(), rand_q15()};
      end
    endcase
    return p;
  endfunction

  function automatic pair_beat_t make_pair(logic [31:0] s, logic [30:0] r, logic [31:0] b,
                                           logic [30:0] h, logic [15:0] w, logic [44:0] q);
    return '{s, s, s, r, b, b, b, h, h, h, w, q};
  endfunction

  task automatic send_pair(pair_beat_t p);
    int n;
    n = gap_len();
    if (n > 0) begin
      pair.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    pair.valid <= 1'b1;
    {pair.sphere_x, pair.sphere_y, pair.sphere_z, pair.sphere_radius, pair.box_x,
     pair.box_y, pair.box_z, pair.half_x, pair.half_y, pair.half_z, pair.quat_w,
     pair.quat_xyz} <= p;
    @(posedge clk);
    while (!pair.ready) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    pair.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    pair_beat_t dir[$];
    sent = 0;
    pair.valid = 1'b0;
    {pair.sphere_x, pair.sphere_y, pair.sphere_z, pair.sphere_radius, pair.box_x,
     pair.box_y, pair.box_z, pair.half_x, pair.half_y, pair.half_z, pair.quat_w,
     pair.quat_xyz} = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Centre inside the box, a near miss, a clear hit, rotated boxes and the field extremes.
    dir = {dir, make_pair(32'h0, 31'h1_0000, 32'h0, 31'h2_0000, 16'sd16384, '0)};
    dir = {dir, make_pair(32'h5_0000, 31'h1_0000, 32'h0, 31'h2_0000, 16'sd16384, '0)};
    dir = {dir, make_pair(32'h2_8000, 31'h1_0000, 32'h0, 31'h2_0000, 16'sd16384, '0)};
    dir = {dir, make_pair(32'h2_8000, 31'h0, 32'h0, 31'h2_0000, 16'sd16384, '0)};
    dir = {dir, make_pair(32'h8000_0000, 31'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff,
                          16'sd16384, '0)};
    dir = {dir, make_pair(32'h7fff_ffff, 31'h7fff_ffff, 32'h8000_0000, 31'h0,
                          16'sd16384, '0)};
    dir = {dir, make_pair(32'h7fff_ffff, 31'h0, 32'h8000_0000, 31'h7fff_ffff,
                          -16'sd16384, '0)};
    dir = {dir, make_pair(32'h3_0000, 31'h2_0000, 32'h0, 31'h1_0000, 16'sd11585,
                          {15'd0, 15'd0, 15'd11585})};
    dir = {dir, make_pair(32'h3_0000, 31'h4_0000, 32'h0, 31'h1_0000, 16'sd0,
                          {15'd16384, 15'd0, 15'd0})};
    dir = {dir, make_pair(32'h1_0000, 31'h4_0000, 32'h0, 31'h1_0000, 16'sh8000,
                          45'h1fff_ffff_ffff)};
    dir = {dir, make_pair(32'h1_0000, 31'h4_0000, 32'h0, 31'h1_0000, 16'sh7fff,
                          {15'h3fff, 15'h4000, 15'h7fff})};
    dir = {dir, make_pair(32'h9_0000, 31'h7fff_ffff, 32'h0, 31'h1_0000, 16'sd0, '0)};
    foreach (dir[i]) send_pair(dir[i]);
    drain();

    for (int i = 0; i < RandomPairs; i++) begin
      send_pair(rand_pair());
      if (i == RandomPairs / 2) drain();
    end
    drain();
    pair.valid <= 1'b0;
    repeat (Latency + 20) @(posedge clk);

    $display("%0d pairs sent: %0d hits, %0d with the centre on or in the box",
             sent, hit_count, degen_count);
    $display("directed extremes, saturated points, non-unit quaternions, random stalls");
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire
